### rtl/core/fpmp_pkg.sv
// ----------------------------------------------------------------------------
// fpmp_pkg
// Shared codes, field offsets and helpers for the framed pattern message
// parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fpmp_pkg;

    // Buffer depth default and width of the little-endian value fields
    localparam int unsigned SAMPLE_DEPTH_DEF = 256;
    localparam int unsigned FIELD_BYTES      = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_CODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER_CODE = 2'd3;

    localparam logic [7:0] PATTERN_CODE_RST   = 8'd1;
    localparam logic [7:0] FREQUENCY_CODE_RST = 8'd2;
    localparam logic [7:0] AMPLITUDE_CODE_RST = 8'd3;
    localparam logic [7:0] DELIMITER_CODE_RST = 8'd10;

    // Input kinds
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Message type codes
    localparam logic [1:0] MSG_NONE    = 2'd0;
    localparam logic [1:0] MSG_PATTERN = 2'd1;
    localparam logic [1:0] MSG_FREQ    = 2'd2;
    localparam logic [1:0] MSG_AMP     = 2'd3;

    // Expected byte codes
    localparam logic [1:0] PH_NONE   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_DELIM  = 2'd3;

    // Block codes while receiving
    localparam logic [1:0] STK_ALL = 2'd0;
    localparam logic [1:0] STK_A   = 2'd1;
    localparam logic [1:0] STK_B   = 2'd2;
    localparam logic [1:0] STK_C   = 2'd3;

    // Buffer codes of a read request; RD_NONE selects no buffer and reads 0
    localparam logic [1:0] RD_A    = 2'd0;
    localparam logic [1:0] RD_B    = 2'd1;
    localparam logic [1:0] RD_C    = 2'd2;
    localparam logic [1:0] RD_NONE = 2'd3;

    // Error flag bits
    localparam int unsigned ERR_TYPE  = 0;
    localparam int unsigned ERR_CAP   = 1;
    localparam int unsigned ERR_DELIM = 2;

    // Result tdata layout
    localparam int unsigned OFS_TYPE  = 0;
    localparam int unsigned OFS_PHASE = 2;
    localparam int unsigned OFS_STACK = 4;
    localparam int unsigned OFS_ERR   = 6;
    localparam int unsigned OFS_FREQ  = 9;
    localparam int unsigned OFS_AMP   = 25;
    localparam int unsigned OFS_COUNT = 41;
    localparam int unsigned OFS_RDATA = 57;
    localparam int unsigned IN_W      = 24;
    localparam int unsigned OUT_W     = 72;

    // Replace byte idx of a 16-bit little-endian value
    function automatic logic [15:0] put_byte(input logic [15:0] old,
                                             input logic [7:0]  b,
                                             input logic [15:0] idx);
        logic [15:0] res;
        res = old;
        if (idx == 16'd0) begin
            res = {old[15:8], b};
        end else if (idx == 16'd1) begin
            res = {b, old[7:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/framed_pattern_message_parser.sv
// ----------------------------------------------------------------------------
// framed_pattern_message_parser
// Byte-wise parser for frequency, amplitude and three-block pattern messages.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per beat. s_tuser selects the kind: 0 carries a
//   received serial byte, 1 reads a stored sample (buffer and index in tdata).
//   m_ channel: one result per request with the parser state after it;
//   m_tlast is high when the request completed a message.
//   cfg_ port: write type codes and the delimiter while the block is idle.
// Pipeline: a request is held in the input register (sample buffer read in
//   flight), then its result in the result register.
// Throughput: one request per cycle while m_tready is high, set by the
//   combinational state update between the two registers; the buffers are
//   one write and one read port each, forwarding a read right behind a write.
// Reset: synchronous, active low. Parser state, values and type codes return
//   to their defaults; the sample buffers keep their contents.
// Stall: while m_tready is low the result holds; one more request is taken
//   into the input register, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_pattern_message_parser #(
    parameter int unsigned SAMPLE_DEPTH = fpmp_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [fpmp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [7:0]                      cfg_wr_data,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: rx_byte[7:0], read_stack[9:8], read_index[17:10], zero fill
    input  wire logic [fpmp_pkg::IN_W-1:0]       s_tdata,
    // tuser: kind
    input  wire logic                            s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: message_type[1:0], byte_phase[3:2], current_stack[5:4],
    //        error_flags[8:6], frequency[24:9], amplitude[40:25],
    //        samples_per_block[56:41], read_data[64:57], zero fill
    output logic [fpmp_pkg::OUT_W-1:0]           m_tdata,
    // tlast: message_done
    output logic                                 m_tlast
);

    localparam int unsigned ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH17 = 17'(SAMPLE_DEPTH);
    localparam logic [15:0] FB16    = 16'(fpmp_pkg::FIELD_BYTES);

    // configuration registers
    logic [7:0] pat_code_reg, freq_code_reg, amp_code_reg, delim_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_code_reg   <= fpmp_pkg::PATTERN_CODE_RST;
            freq_code_reg  <= fpmp_pkg::FREQUENCY_CODE_RST;
            amp_code_reg   <= fpmp_pkg::AMPLITUDE_CODE_RST;
            delim_code_reg <= fpmp_pkg::DELIMITER_CODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                fpmp_pkg::CFG_PATTERN_CODE:   pat_code_reg   <= cfg_wr_data;
                fpmp_pkg::CFG_FREQUENCY_CODE: freq_code_reg  <= cfg_wr_data;
                fpmp_pkg::CFG_AMPLITUDE_CODE: amp_code_reg   <= cfg_wr_data;
                fpmp_pkg::CFG_DELIMITER_CODE: delim_code_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic m_tvalid_reg;
    logic s1_adv;
    logic accept;

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // request fields
    logic [7:0]        in_byte;
    logic [1:0]        in_rstack;
    logic [7:0]        in_rindex;
    logic [ADDR_W+7:0] in_rindex_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_rd_ok;

    assign in_byte       = s_tdata[7:0];
    assign in_rstack     = s_tdata[9:8];
    assign in_rindex     = s_tdata[17:10];
    assign in_rindex_ext = {{ADDR_W{1'b0}}, in_rindex};
    assign rd_addr       = in_rindex_ext[ADDR_W-1:0];
    assign in_rd_ok      = ({9'd0, in_rindex} < DEPTH17) && (in_rstack != fpmp_pkg::RD_NONE);

    // parser state
    logic [1:0]  type_reg, phase_reg, stack_reg;
    logic [2:0]  err_reg;
    logic [15:0] pos_reg, freq_reg, amp_reg, count_reg;
    logic [1:0]  type_next, phase_next, stack_next;
    logic [2:0]  err_next;
    logic [15:0] pos_next, freq_next, amp_next, count_next;
    logic [15:0] pos_inc;
    logic        done;
    logic        wr_en;

    // input register
    logic        s1_kind_reg;
    logic [7:0]  s1_byte_reg;
    logic [1:0]  s1_rstack_reg;
    logic        s1_rd_ok_reg;
    logic        byp_hit_reg;
    logic [7:0]  byp_data_reg;

    // buffer write side
    logic [ADDR_W+15:0] pos_ext;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_fire;
    logic               wr_hit;
    logic [7:0]         rdata_a, rdata_b, rdata_c;
    logic [7:0]         rd_val;

    assign pos_ext = {{ADDR_W{1'b0}}, pos_reg};
    assign wr_addr = pos_ext[ADDR_W-1:0];
    assign pos_inc = pos_reg + 16'd1;
    assign wr_fire = wr_en && s1_adv;

    // a read taken at the same edge as a write to its entry sees old RAM data
    assign wr_hit = wr_fire && (wr_addr == rd_addr) &&
                    (((stack_reg == fpmp_pkg::STK_A) && (in_rstack == fpmp_pkg::RD_A)) ||
                     ((stack_reg == fpmp_pkg::STK_B) && (in_rstack == fpmp_pkg::RD_B)) ||
                     ((stack_reg == fpmp_pkg::STK_C) && (in_rstack == fpmp_pkg::RD_C)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg   <= s_tuser;
            s1_byte_reg   <= in_byte;
            s1_rstack_reg <= in_rstack;
            s1_rd_ok_reg  <= in_rd_ok;
            byp_hit_reg   <= wr_hit;
            byp_data_reg  <= s1_byte_reg;
        end
    end

    fpmp_ram #(.WIDTH(8), .DEPTH(SAMPLE_DEPTH)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_fire && (stack_reg == fpmp_pkg::STK_A)),
        .wr_addr (wr_addr),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rdata_a)
    );

    fpmp_ram #(.WIDTH(8), .DEPTH(SAMPLE_DEPTH)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_fire && (stack_reg == fpmp_pkg::STK_B)),
        .wr_addr (wr_addr),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rdata_b)
    );

    fpmp_ram #(.WIDTH(8), .DEPTH(SAMPLE_DEPTH)) u_ram_c (
        .aclk    (aclk),
        .wr_en   (wr_fire && (stack_reg == fpmp_pkg::STK_C)),
        .wr_addr (wr_addr),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rdata_c)
    );

    always_comb begin
        rd_val = 8'd0;
        if (s1_kind_reg == fpmp_pkg::KIND_READ && s1_rd_ok_reg) begin
            if (byp_hit_reg) begin
                rd_val = byp_data_reg;
            end else begin
                unique case (s1_rstack_reg)
                    fpmp_pkg::RD_A: rd_val = rdata_a;
                    fpmp_pkg::RD_B: rd_val = rdata_b;
                    fpmp_pkg::RD_C: rd_val = rdata_c;
                    default:        rd_val = 8'd0;
                endcase
            end
        end
    end

    // one-byte state update
    always_comb begin
        type_next  = type_reg;
        phase_next = phase_reg;
        stack_next = stack_reg;
        err_next   = err_reg;
        pos_next   = pos_reg;
        freq_next  = freq_reg;
        amp_next   = amp_reg;
        count_next = count_reg;
        done       = 1'b0;
        wr_en      = 1'b0;
        if (s1_kind_reg == fpmp_pkg::KIND_RX) begin
            case (type_reg)
                fpmp_pkg::MSG_NONE: begin
                    if (s1_byte_reg == pat_code_reg) begin
                        type_next  = fpmp_pkg::MSG_PATTERN;
                        phase_next = fpmp_pkg::PH_LENGTH;
                    end else if (s1_byte_reg == freq_code_reg) begin
                        type_next  = fpmp_pkg::MSG_FREQ;
                        phase_next = fpmp_pkg::PH_DATA;
                    end else if (s1_byte_reg == amp_code_reg) begin
                        type_next  = fpmp_pkg::MSG_AMP;
                        phase_next = fpmp_pkg::PH_DATA;
                    end else begin
                        phase_next = fpmp_pkg::PH_NONE;
                        err_next[fpmp_pkg::ERR_TYPE] = 1'b1;
                    end
                    stack_next = fpmp_pkg::STK_ALL;
                    pos_next   = 16'd0;
                end
                fpmp_pkg::MSG_FREQ, fpmp_pkg::MSG_AMP: begin
                    if (type_reg == fpmp_pkg::MSG_FREQ) begin
                        freq_next = fpmp_pkg::put_byte(freq_reg, s1_byte_reg, pos_reg);
                    end else begin
                        amp_next = fpmp_pkg::put_byte(amp_reg, s1_byte_reg, pos_reg);
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= FB16) begin
                        done = 1'b1;
                    end
                end
                default: begin
                    case (phase_reg)
                        fpmp_pkg::PH_LENGTH: begin
                            count_next = fpmp_pkg::put_byte(count_reg, s1_byte_reg, pos_reg);
                            pos_next   = pos_inc;
                            if (pos_inc >= FB16) begin
                                phase_next = fpmp_pkg::PH_DATA;
                                stack_next = fpmp_pkg::STK_A;
                                pos_next   = 16'd0;
                                if ({1'b0, count_next} > DEPTH17) begin
                                    err_next[fpmp_pkg::ERR_CAP] = 1'b1;
                                end
                            end
                        end
                        fpmp_pkg::PH_DATA: begin
                            wr_en = (err_reg == 3'd0) && (pos_reg < count_reg) &&
                                    ({1'b0, pos_reg} < DEPTH17);
                            pos_next = pos_inc;
                            if (pos_inc >= count_reg) begin
                                phase_next = fpmp_pkg::PH_DELIM;
                            end
                        end
                        fpmp_pkg::PH_DELIM: begin
                            if (s1_byte_reg == delim_code_reg) begin
                                case (stack_reg)
                                    fpmp_pkg::STK_A: begin
                                        stack_next = fpmp_pkg::STK_B;
                                        phase_next = fpmp_pkg::PH_DATA;
                                    end
                                    fpmp_pkg::STK_B: begin
                                        stack_next = fpmp_pkg::STK_C;
                                        phase_next = fpmp_pkg::PH_DATA;
                                    end
                                    fpmp_pkg::STK_C: done = 1'b1;
                                    default: ;
                                endcase
                            end else begin
                                err_next[fpmp_pkg::ERR_DELIM] = 1'b1;
                            end
                            pos_next = 16'd0;
                        end
                        default: ;
                    endcase
                end
            endcase
            // message end clears the framing state
            if (done) begin
                type_next  = fpmp_pkg::MSG_NONE;
                phase_next = fpmp_pkg::PH_NONE;
                stack_next = fpmp_pkg::STK_ALL;
                err_next   = 3'd0;
                pos_next   = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_reg  <= fpmp_pkg::MSG_NONE;
            phase_reg <= fpmp_pkg::PH_NONE;
            stack_reg <= fpmp_pkg::STK_ALL;
            err_reg   <= 3'd0;
            pos_reg   <= 16'd0;
            freq_reg  <= 16'd0;
            amp_reg   <= 16'd0;
            count_reg <= 16'd0;
        end else if (s1_adv) begin
            type_reg  <= type_next;
            phase_reg <= phase_next;
            stack_reg <= stack_next;
            err_reg   <= err_next;
            pos_reg   <= pos_next;
            freq_reg  <= freq_next;
            amp_reg   <= amp_next;
            count_reg <= count_next;
        end
    end

    // result register
    logic [fpmp_pkg::OUT_W-1:0] m_tdata_reg;
    logic                       m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_tdata_reg <= {7'd0, rd_val, count_next, amp_next, freq_next,
                            err_next, stack_next, phase_next, type_next};
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

### rtl/core/fpmp_ram.sv
// ----------------------------------------------------------------------------
// fpmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/fpmp_checker.sv
// ----------------------------------------------------------------------------
// fpmp_checker
// Port-level assertions for the framed pattern message parser.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmp_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic                        m_tlast,
    input wire logic [fpmp_pkg::OUT_W-1:0]  m_tdata
);

    logic [1:0] r_type, r_phase, r_stack;
    logic [2:0] r_err;

    assign r_type  = m_tdata[fpmp_pkg::OFS_TYPE +: 2];
    assign r_phase = m_tdata[fpmp_pkg::OFS_PHASE +: 2];
    assign r_stack = m_tdata[fpmp_pkg::OFS_STACK +: 2];
    assign r_err   = m_tdata[fpmp_pkg::OFS_ERR +: 3];

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a completed message leaves the parser fully idle with flags cleared
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> r_type == fpmp_pkg::MSG_NONE &&
            r_phase == fpmp_pkg::PH_NONE && r_stack == fpmp_pkg::STK_ALL && r_err == 3'd0)
        else $error("message end did not clear framing state");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r_type == fpmp_pkg::MSG_NONE |->
            r_phase == fpmp_pkg::PH_NONE && r_stack == fpmp_pkg::STK_ALL)
        else $error("idle parser shows a phase or block");

    a_value_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r_type == fpmp_pkg::MSG_FREQ || r_type == fpmp_pkg::MSG_AMP) |->
            r_phase == fpmp_pkg::PH_DATA && r_stack == fpmp_pkg::STK_ALL)
        else $error("value message outside data phase");

endmodule

bind framed_pattern_message_parser fpmp_checker u_fpmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);

`default_nettype wire
